@@ rtl/sdtq_pkg.sv @@
// ----------------------------------------------------------------------------
// sdtq_pkg: shared types and codes for the sorted deadline timer queue
// Holds the timer entry layout, the per-cell control word and the command
// and status codes.
// ----------------------------------------------------------------------------
package sdtq_pkg;

  localparam int DEADLINE_W = 48;
  localparam int DELAY_W    = 32;
  localparam int ID_W       = 32;
  localparam int TAG_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int CMD_W      = 2;

  localparam int MAX_RESULTS = 16;
  localparam int POP_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 3'd5;

  typedef struct packed {
    logic [DEADLINE_W-1:0] deadline;
    logic [ID_W-1:0]       id;
    logic [TAG_W-1:0]      tag;
  } entry_t;

  typedef struct packed {
    logic                  insert;
    logic                  shift;
    logic [DEADLINE_W-1:0] key;
    logic [ID_W-1:0]       target;
    entry_t                new_entry;
  } cell_ctl_t;

endpackage

@@ rtl/sorted_deadline_timer_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue: bounded queue of one-shot timers in deadline
// order
// A chain of cells keeps the timers sorted; a small sequencer runs add,
// remove and tick commands and drives a registered result stream.
//
//   Channel  Dir  Word                                    Handshake
//   s_*      in   tuser=command, tdata=now/delay/tag/id   s_tvalid/s_tready
//   m_*      out  tdata=status/id/tag, tlast=last         m_tvalid/m_tready
//
// Add and remove first accept the word and register the deadline sum and id
// match vector, then update the cell chain.
// A tick returns n results (1 to 16), one pop per cycle while the result register is free.
// A new word is accepted only when the previous command has finished.
// A stalled result register holds the sequencer; reset empties the queue.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue
  import sdtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [127:0]  s_tdata,  // now_ms[47:0], delay_ms[79:48],
                                  // callback_tag[95:80], target_id[127:96]
  input  logic [1:0]    s_tuser,  // command[1:0]
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [55:0]   m_tdata,  // status[2:0], timer_id[34:3],
                                  // expired_tag[50:35], zero fill [55:51]
  output logic          m_tlast
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_EXEC = 1'b1;

  logic [0:0]             state;
  logic [CMD_W-1:0]       cmd_q;
  logic [DEADLINE_W-1:0]  key_q;
  logic [TAG_W-1:0]       tag_q;
  logic [ID_W-1:0]        target_q;
  logic [QUEUE_DEPTH-1:0] match_q;
  logic [POP_W-1:0]       pops;
  logic [POP_W-1:0]       pops_next;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [ID_W-1:0]        id_counter;
  logic [ID_W-1:0]        id_counter_next;

  logic [STATUS_W-1:0]    out_status;
  logic [ID_W-1:0]        out_id;
  logic [TAG_W-1:0]       out_tag;
  logic                   out_last;

  logic [CMD_W-1:0]       in_cmd;
  logic [DEADLINE_W-1:0]  in_now;
  logic [DELAY_W-1:0]     in_delay;
  logic [TAG_W-1:0]       in_tag;
  logic [ID_W-1:0]        in_target;
  logic [DEADLINE_W:0]    dl_sum;
  logic [DEADLINE_W-1:0]  dl_sat;

  cell_ctl_t              ctl;
  entry_t                 cell_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] le;
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH-1:0] take_right;
  logic [QUEUE_DEPTH-1:0] rm_low;
  logic [QUEUE_DEPTH-1:0] rm_mask;
  logic                   rm_found;

  logic                   accept;
  logic                   out_free;
  logic                   emit;
  logic                   done;
  logic                   do_insert;
  logic                   do_shift;
  logic                   full;
  logic [STATUS_W-1:0]    e_status;
  logic [ID_W-1:0]        e_id;
  logic [TAG_W-1:0]       e_tag;
  logic                   e_last;
  logic [POP_W-1:0]       pops_inc;

  assign in_cmd    = s_tuser;
  assign in_now    = s_tdata[47:0];
  assign in_delay  = s_tdata[79:48];
  assign in_tag    = s_tdata[95:80];
  assign in_target = s_tdata[127:96];

  assign dl_sum = {1'b0, in_now} + {{(DEADLINE_W + 1 - DELAY_W){1'b0}}, in_delay};
  assign dl_sat = dl_sum[DEADLINE_W] ? {DEADLINE_W{1'b1}} : dl_sum[DEADLINE_W-1:0];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign pops_inc = pops + POP_W'(1);

  assign rm_low   = match_q & (~match_q + QUEUE_DEPTH'(1));
  assign rm_mask  = ~(rm_low - QUEUE_DEPTH'(1));
  assign rm_found = |match_q;

  assign ctl.insert              = do_insert;
  assign ctl.shift               = do_shift;
  assign ctl.key                 = key_q;
  assign ctl.target              = in_target;
  assign ctl.new_entry.deadline  = key_q;
  assign ctl.new_entry.id        = id_counter + ID_W'(1);
  assign ctl.new_entry.tag       = tag_q;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      entry_t left_entry;
      entry_t right_entry;
      logic   left_le;

      assign occ[gi] = (CNT_W'(gi) < count);

      if (gi == 0) begin : g_head
        assign left_entry = ctl.new_entry;
        assign left_le    = 1'b1;
      end else begin : g_mid
        assign left_entry = cell_q[gi-1];
        assign left_le    = le[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign right_entry = cell_q[gi];
      end else begin : g_body
        assign right_entry = cell_q[gi+1];
      end

      sdtq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occ         (occ[gi]),
        .take_right  (take_right[gi]),
        .left_entry  (left_entry),
        .left_le     (left_le),
        .right_entry (right_entry),
        .entry       (cell_q[gi]),
        .le          (le[gi]),
        .match       (match[gi])
      );
    end
  endgenerate

  always_comb begin
    emit            = 1'b0;
    done            = 1'b0;
    do_insert       = 1'b0;
    do_shift        = 1'b0;
    take_right      = '0;
    e_status        = ST_NONE_DUE;
    e_id            = '0;
    e_tag           = '0;
    e_last          = 1'b1;
    count_next      = count;
    id_counter_next = id_counter;
    pops_next       = pops;
    if (state == S_EXEC) begin
      unique case (cmd_q)
        CMD_ADD: begin
          if (out_free) begin
            emit = 1'b1;
            done = 1'b1;
            if (full) begin
              e_status = ST_FULL;
            end else begin
              do_insert       = 1'b1;
              count_next      = count + CNT_W'(1);
              id_counter_next = id_counter + ID_W'(1);
              e_status        = ST_ADDED;
              e_id            = id_counter + ID_W'(1);
            end
          end
        end
        CMD_REMOVE: begin
          if (out_free) begin
            emit = 1'b1;
            done = 1'b1;
            e_id = target_q;
            if (rm_found) begin
              do_shift   = 1'b1;
              take_right = rm_mask;
              count_next = count - CNT_W'(1);
              e_status   = ST_REMOVED;
            end else begin
              e_status = ST_NOT_FOUND;
            end
          end
        end
        CMD_TICK: begin
          if (out_free) begin
            emit = 1'b1;
            if (le[0] && (pops < POP_W'(MAX_RESULTS))) begin
              do_shift   = 1'b1;
              take_right = '1;
              count_next = count - CNT_W'(1);
              pops_next  = pops_inc;
              e_status   = ST_EXPIRED;
              e_id       = cell_q[0].id;
              e_tag      = cell_q[0].tag;
              e_last     = !((pops_inc < POP_W'(MAX_RESULTS)) && le[1]);
              done       = e_last;
            end else begin
              done = 1'b1;
            end
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      id_counter <= '0;
      pops       <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      count      <= count_next;
      id_counter <= id_counter_next;
      pops       <= pops_next;
      if (accept) begin
        state <= S_EXEC;
        pops  <= '0;
      end else if (done) begin
        state <= S_IDLE;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= in_cmd;
      key_q    <= (in_cmd == CMD_ADD) ? dl_sat : in_now;
      tag_q    <= in_tag;
      target_q <= in_target;
      match_q  <= match;
    end
    if (emit) begin
      out_status <= e_status;
      out_id     <= e_id;
      out_tag    <= e_tag;
      out_last   <= e_last;
    end
  end

  assign m_tdata = {5'b0, out_tag, out_id, out_status};
  assign m_tlast = out_last;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("Entry count exceeds the queue depth.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(count) && $stable(id_counter)))
    else $error("Queue state changed while the result word was stalled.");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    occ[1] |-> (cell_q[0].deadline <= cell_q[1].deadline))
    else $error("Head entries are out of deadline order.");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> (count == $past(count) + CNT_W'(1)))
    else $error("Insert did not grow the queue by one entry.");
`endif

endmodule

@@ rtl/sdtq_cell.sv @@
// ----------------------------------------------------------------------------
// sdtq_cell: one slot of the sorted timer chain
// Holds one timer entry. On insert it keeps its entry, takes the new one or
// takes its left neighbor's; on shift, when take_right is set, it takes its right neighbor's.
// ----------------------------------------------------------------------------
module sdtq_cell
  import sdtq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  logic      take_right,
  input  entry_t    left_entry,
  input  logic      left_le,
  input  entry_t    right_entry,
  output entry_t    entry,
  output logic      le,
  output logic      match
);

  entry_t q;

  assign entry = q;
  assign le    = occ && (q.deadline <= ctl.key);
  assign match = occ && (q.id == ctl.target);

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (!le) begin
        if (left_le) begin
          q <= ctl.new_entry;
        end else begin
          q <= left_entry;
        end
      end
    end else if (ctl.shift && take_right) begin
      q <= right_entry;
    end
  end

endmodule
